### hw/rtl/ir_wall_sensor_conditioner_defines.svh
// Assertion macros used by the top-level RTL; empty when synthesizing.
`ifndef IR_WALL_SENSOR_CONDITIONER_DEFINES_SVH
`define IR_WALL_SENSOR_CONDITIONER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication
`define IWSC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("iwsc assertion failed");
// Next-cycle implication
`define IWSC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("iwsc assertion failed");
`else
`define IWSC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define IWSC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### hw/rtl/iwsc_pkg.sv
package iwsc_pkg;

    // Channel order inside every packed group
    localparam int NUM_CH = 4;
    localparam int CH_FL  = 0;
    localparam int CH_FR  = 1;
    localparam int CH_DL  = 2;
    localparam int CH_DR  = 3;

    // Result flags, packed above the values
    localparam int NUM_FLAGS = 6;

    // Register map
    localparam int CFG_IDX_W = 4;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFS_FL      = 4'd0,
        CFG_OFS_FR      = 4'd1,
        CFG_OFS_DL      = 4'd2,
        CFG_OFS_DR      = 4'd3,
        CFG_SIDE_WALL   = 4'd4,
        CFG_FRONT_WALL  = 4'd5,
        CFG_FRONT_NEAR  = 4'd6,
        CFG_SIDE_NEAR   = 4'd7
    } cfg_idx_t;

    // Register reset values, cut to the ADC width where used
    localparam int RST_OFS_FL     = 2000;
    localparam int RST_OFS_FR     = 1330;
    localparam int RST_OFS_DL     = 1560;
    localparam int RST_OFS_DR     = 745;
    localparam int RST_SIDE_WALL  = 500;
    localparam int RST_FRONT_WALL = 150;
    localparam int RST_FRONT_NEAR = 1000;
    localparam int RST_SIDE_NEAR  = 3000;

    // Pipeline strobes handed to the window stage
    typedef struct packed {
        logic accept;   // beat taken on the slave side, issue window read
        logic retire;   // window update completes, result loads output
    } pipe_ctrl_t;

endpackage

### hw/rtl/iwsc_ram.sv
module iwsc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 15
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/iwsc_correct.sv
module iwsc_correct import iwsc_pkg::*; #(
    parameter int ADC_BITS = 12
) (
    input  logic                aclk,
    input  logic                load,
    input  logic [ADC_BITS-1:0] ambient [NUM_CH],
    input  logic [ADC_BITS-1:0] lit [NUM_CH],
    input  logic [ADC_BITS-1:0] offset [NUM_CH],
    input  logic [ADC_BITS-1:0] front_near_level,
    input  logic [ADC_BITS-1:0] side_near_level,
    output logic [ADC_BITS-1:0] value [NUM_CH],
    output logic                front_near,
    output logic                left_near,
    output logic                right_near
);

    logic [ADC_BITS-1:0] value_next [NUM_CH];
    logic [ADC_BITS-1:0] value_reg [NUM_CH];
    logic                front_near_reg;
    logic                left_near_reg;
    logic                right_near_reg;

    // lit - (ambient + offset), floored at zero
    always_comb begin
        logic [ADC_BITS:0] sub;
        logic [ADC_BITS:0] lit_ext;
        for (int i = 0; i < NUM_CH; i++) begin
            sub     = {1'b0, ambient[i]} + {1'b0, offset[i]};
            lit_ext = {1'b0, lit[i]};
            value_next[i] = (lit_ext > sub) ? ADC_BITS'(lit_ext - sub) : '0;
        end
    end

    // Payload stage, loaded on each accepted beat
    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < NUM_CH; i++) begin
                value_reg[i] <= value_next[i];
            end
            front_near_reg <= (value_next[CH_FL] > front_near_level) ||
                              (value_next[CH_FR] > front_near_level);
            left_near_reg  <= value_next[CH_DL] > side_near_level;
            right_near_reg <= value_next[CH_DR] > side_near_level;
        end
    end

    assign value      = value_reg;
    assign front_near = front_near_reg;
    assign left_near  = left_near_reg;
    assign right_near = right_near_reg;

endmodule

### hw/rtl/iwsc_window.sv
module iwsc_window import iwsc_pkg::*; #(
    parameter int WINDOW_LEN = 15,
    parameter int ADC_BITS   = 12,
    parameter int SUM_W      = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  pipe_ctrl_t          ctrl,
    input  logic [ADC_BITS-1:0] value [NUM_CH],
    input  logic [SUM_W-1:0]    side_lim,
    input  logic [SUM_W:0]      front_lim,
    output logic                left_wall,
    output logic                right_wall,
    output logic                front_wall
);

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int WORD_W = NUM_CH * ADC_BITS;

    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    logic [WINDOW_LEN-1:0] fill_reg;
    logic                  old_valid_reg;
    logic [SUM_W-1:0]      sum_reg [NUM_CH];
    logic [SUM_W-1:0]      sum_next [NUM_CH];
    logic [WORD_W-1:0]     rd_word;
    logic [WORD_W-1:0]     wr_word;
    logic [SUM_W:0]        front_sum;

    // Slot advances before the write, wrapping at the window length
    always_comb begin
        if (slot_reg == SLOT_W'(WINDOW_LEN - 1)) begin
            slot_next = '0;
        end else begin
            slot_next = slot_reg + 1'b1;
        end
    end

    // One word holds the slot of all four channels
    iwsc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(WINDOW_LEN)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ctrl.retire),
        .wr_addr(slot_reg),
        .wr_data(wr_word),
        .rd_en  (ctrl.accept),
        .rd_addr(slot_next),
        .rd_data(rd_word)
    );

    // Running sums: drop the evicted value, add the new one.
    // Slots never written read as zero through the fill bits.
    always_comb begin
        logic [ADC_BITS-1:0] old_val;
        for (int i = 0; i < NUM_CH; i++) begin
            old_val = old_valid_reg ? rd_word[i*ADC_BITS +: ADC_BITS] : '0;
            sum_next[i] = sum_reg[i] - SUM_W'(old_val) + SUM_W'(value[i]);
            wr_word[i*ADC_BITS +: ADC_BITS] = value[i];
        end
    end

    // Wall flags on the sums after this scan entered the windows
    assign front_sum  = {1'b0, sum_next[CH_FL]} + {1'b0, sum_next[CH_FR]};
    assign left_wall  = sum_next[CH_DL] > side_lim;
    assign right_wall = sum_next[CH_DR] > side_lim;
    assign front_wall = front_sum > front_lim;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            fill_reg      <= '0;
            old_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CH; i++) begin
                sum_reg[i] <= '0;
            end
        end else begin
            if (ctrl.accept) begin
                slot_reg      <= slot_next;
                old_valid_reg <= fill_reg[slot_next];
            end
            if (ctrl.retire) begin
                fill_reg[slot_reg] <= 1'b1;
                for (int i = 0; i < NUM_CH; i++) begin
                    sum_reg[i] <= sum_next[i];
                end
            end
        end
    end

endmodule

### hw/rtl/ir_wall_sensor_conditioner.sv
// IR wall sensor conditioner.
// Slave stream (s_*): one beat is one scan, ambient and lit readings of the
// front left, front right, diagonal left and diagonal right emitters.
// Master stream (m_*): one beat per scan, the four corrected values
// (lit - ambient - offset, floored at zero) and six flags: side and front
// walls from WINDOW_LEN-scan running sums, near flags from the scan itself.
// Config channel (cfg_*): register index and data, always ready; write only
// while the block holds no scan. Indexes past the register map are dropped.
// Path: an accepted slave beat is registered in the window stage and then in
// the output register, which raises m_tvalid. Throughput: one beat per cycle
// while m_tready keeps up; the window RAM is read on accept (registered read)
// and written back when the scan leaves the window stage, so successive scans
// touch different slots.
// Reset: config registers load their defaults, the windows read as all
// zero through per-slot fill bits, and the slot pointer starts at zero
// (first scan goes to slot 1). No clearing pass is needed.
// Stall: a result waits in the output register; one more scan may sit in
// the window stage, after which s_tready drops until m_tready returns.
`include "ir_wall_sensor_conditioner_defines.svh"

module ir_wall_sensor_conditioner import iwsc_pkg::*; #(
    parameter int WINDOW_LEN = 15,
    parameter int ADC_BITS   = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // fl_ambient, fl_lit, fr_ambient, fr_lit, dl_ambient, dl_lit,
    // dr_ambient, dr_lit (ADC_BITS each), zero pad
    input  logic [((8*ADC_BITS+7)/8)*8-1:0]     s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // fl_value, fr_value, dl_value, dr_value (ADC_BITS each), left_wall,
    // right_wall, front_wall, front_near, left_near, right_near, zero pad
    output logic [((4*ADC_BITS+6+7)/8)*8-1:0]   m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [CFG_IDX_W-1:0]                cfg_index,
    input  logic [ADC_BITS-1:0]                 cfg_data
);

    localparam int OUT_W = ((4*ADC_BITS+NUM_FLAGS+7)/8)*8;
    localparam int SUM_W = ADC_BITS + $clog2(WINDOW_LEN);

    // Configuration registers
    logic [ADC_BITS-1:0] ofs_fl_reg, ofs_fr_reg, ofs_dl_reg, ofs_dr_reg;
    logic [ADC_BITS-1:0] side_wall_reg, front_wall_reg;
    logic [ADC_BITS-1:0] front_near_reg, side_near_reg;
    logic [SUM_W-1:0]    side_lim_reg;
    logic [SUM_W:0]      front_lim_reg;

    // Pipeline control
    logic       stage_valid_reg;
    logic       stage_valid_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [OUT_W-1:0] out_data_reg;
    pipe_ctrl_t ctrl;

    logic [ADC_BITS-1:0] ambient [NUM_CH];
    logic [ADC_BITS-1:0] lit [NUM_CH];
    logic [ADC_BITS-1:0] offset [NUM_CH];
    logic [ADC_BITS-1:0] value [NUM_CH];
    logic                front_near, left_near, right_near;
    logic                left_wall, right_wall, front_wall;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_fl_reg     <= ADC_BITS'(RST_OFS_FL);
            ofs_fr_reg     <= ADC_BITS'(RST_OFS_FR);
            ofs_dl_reg     <= ADC_BITS'(RST_OFS_DL);
            ofs_dr_reg     <= ADC_BITS'(RST_OFS_DR);
            side_wall_reg  <= ADC_BITS'(RST_SIDE_WALL);
            front_wall_reg <= ADC_BITS'(RST_FRONT_WALL);
            front_near_reg <= ADC_BITS'(RST_FRONT_NEAR);
            side_near_reg  <= ADC_BITS'(RST_SIDE_NEAR);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_OFS_FL:     ofs_fl_reg     <= cfg_data;
                CFG_OFS_FR:     ofs_fr_reg     <= cfg_data;
                CFG_OFS_DL:     ofs_dl_reg     <= cfg_data;
                CFG_OFS_DR:     ofs_dr_reg     <= cfg_data;
                CFG_SIDE_WALL:  side_wall_reg  <= cfg_data;
                CFG_FRONT_WALL: front_wall_reg <= cfg_data;
                CFG_FRONT_NEAR: front_near_reg <= cfg_data;
                CFG_SIDE_NEAR:  side_near_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Wall limits as level times window length (twice that for the front pair), kept registered
    always_ff @(posedge aclk) begin
        side_lim_reg  <= SUM_W'(side_wall_reg) * SUM_W'(WINDOW_LEN);
        front_lim_reg <= (SUM_W+1)'(front_wall_reg) * (SUM_W+1)'(2 * WINDOW_LEN);
    end

    // Handshake: window stage retires when the output register is free or being emptied
    always_comb begin
        ctrl.retire = stage_valid_reg && (!out_valid_reg || m_tready);
        s_tready    = !stage_valid_reg || ctrl.retire;
        ctrl.accept = s_tvalid && s_tready;
    end

    always_comb begin
        stage_valid_next = ctrl.accept ? 1'b1 : (ctrl.retire ? 1'b0 : stage_valid_reg);
        out_valid_next   = ctrl.retire ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Unpack the scan
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            ambient[i] = s_tdata[(2*i)*ADC_BITS +: ADC_BITS];
            lit[i]     = s_tdata[(2*i+1)*ADC_BITS +: ADC_BITS];
        end
        offset[CH_FL] = ofs_fl_reg;
        offset[CH_FR] = ofs_fr_reg;
        offset[CH_DL] = ofs_dl_reg;
        offset[CH_DR] = ofs_dr_reg;
    end

    iwsc_correct #(
        .ADC_BITS(ADC_BITS)
    ) u_correct (
        .aclk            (aclk),
        .load            (ctrl.accept),
        .ambient         (ambient),
        .lit             (lit),
        .offset          (offset),
        .front_near_level(front_near_reg),
        .side_near_level (side_near_reg),
        .value           (value),
        .front_near      (front_near),
        .left_near       (left_near),
        .right_near      (right_near)
    );

    iwsc_window #(
        .WINDOW_LEN(WINDOW_LEN),
        .ADC_BITS  (ADC_BITS),
        .SUM_W     (SUM_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .value     (value),
        .side_lim  (side_lim_reg),
        .front_lim (front_lim_reg),
        .left_wall (left_wall),
        .right_wall(right_wall),
        .front_wall(front_wall)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (ctrl.retire) begin
            out_data_reg <= OUT_W'({right_near, left_near, front_near, front_wall,
                                    right_wall, left_wall, value[CH_DR], value[CH_DL],
                                    value[CH_FR], value[CH_FL]});
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tvalid = out_valid_reg;

    // A full pipeline facing a stalled sink must refuse new beats
    `IWSC_ASSERT_IMP(a_no_overrun, aclk, aresetn,
        stage_valid_reg && out_valid_reg && !m_tready, !s_tready)
    // Every retired scan shows up on the master side
    `IWSC_ASSERT_NXT(a_retire_shows, aclk, aresetn, ctrl.retire, m_tvalid)
    // Every accepted beat occupies the window stage
    `IWSC_ASSERT_NXT(a_accept_held, aclk, aresetn, ctrl.accept, stage_valid_reg)

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iwsc_pkg::*;

    localparam int WIN_LEN     = 15;
    localparam int ADC_W       = 12;
    localparam int ADC_MAX     = (1 << ADC_W) - 1;
    localparam int S_W         = ((8 * ADC_W + 7) / 8) * 8;
    localparam int M_W         = ((4 * ADC_W + 6 + 7) / 8) * 8;
    localparam int NUM_REGS    = int'(CFG_SIDE_NEAR) + 1;
    localparam int IDX_TOP     = (1 << CFG_IDX_W) - 1;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;
    localparam int RPT_MAX     = 40;

    // target codes for a channel: below the floor, or a raw random pair
    localparam int V_BELOW = -1;
    localparam int V_RAW   = -2;

    // slave beat, fl_ambient in the low bits
    typedef struct packed {
        logic [ADC_W-1:0] dr_lit;
        logic [ADC_W-1:0] dr_ambient;
        logic [ADC_W-1:0] dl_lit;
        logic [ADC_W-1:0] dl_ambient;
        logic [ADC_W-1:0] fr_lit;
        logic [ADC_W-1:0] fr_ambient;
        logic [ADC_W-1:0] fl_lit;
        logic [ADC_W-1:0] fl_ambient;
    } scan_beat_t;

    // master beat, fl_value in the low bits
    typedef struct packed {
        logic [1:0]       pad;
        logic             right_near;
        logic             left_near;
        logic             front_near;
        logic             front_wall;
        logic             right_wall;
        logic             left_wall;
        logic [ADC_W-1:0] dr_value;
        logic [ADC_W-1:0] dl_value;
        logic [ADC_W-1:0] fr_value;
        logic [ADC_W-1:0] fl_value;
    } result_beat_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_style_t;

    // Predicts each result from the scans and keeps the expected beats in order
    class sensor_scoreboard;
        logic [ADC_W-1:0] regs [NUM_REGS];
        int               history [NUM_CH][WIN_LEN];
        int               sums [NUM_CH];
        int               slot;
        result_beat_t     expected_q [$];
        int               errors;

        function new();
            regs[CFG_OFS_FL]     = ADC_W'(RST_OFS_FL);
            regs[CFG_OFS_FR]     = ADC_W'(RST_OFS_FR);
            regs[CFG_OFS_DL]     = ADC_W'(RST_OFS_DL);
            regs[CFG_OFS_DR]     = ADC_W'(RST_OFS_DR);
            regs[CFG_SIDE_WALL]  = ADC_W'(RST_SIDE_WALL);
            regs[CFG_FRONT_WALL] = ADC_W'(RST_FRONT_WALL);
            regs[CFG_FRONT_NEAR] = ADC_W'(RST_FRONT_NEAR);
            regs[CFG_SIDE_NEAR]  = ADC_W'(RST_SIDE_NEAR);
            foreach (history[ch, k]) history[ch][k] = 0;
            foreach (sums[ch]) sums[ch] = 0;
            slot   = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ADC_W-1:0] data);
            // out-of-map indexes are dropped
            if (idx < NUM_REGS) begin
                regs[idx] = data;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_scan(scan_beat_t b);
            int           ambient [NUM_CH];
            int           lit [NUM_CH];
            int           value [NUM_CH];
            int           floor_lvl;
            int           side_lim;
            int           front_lim;
            result_beat_t r;
            ambient[CH_FL] = int'(b.fl_ambient);
            ambient[CH_FR] = int'(b.fr_ambient);
            ambient[CH_DL] = int'(b.dl_ambient);
            ambient[CH_DR] = int'(b.dr_ambient);
            lit[CH_FL]     = int'(b.fl_lit);
            lit[CH_FR]     = int'(b.fr_lit);
            lit[CH_DL]     = int'(b.dl_lit);
            lit[CH_DR]     = int'(b.dr_lit);
            // slot advances before the write, so the first scan lands in slot 1
            slot = (slot == WIN_LEN - 1) ? 0 : slot + 1;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                floor_lvl = ambient[ch] + int'(regs[int'(CFG_OFS_FL) + ch]);
                value[ch] = (lit[ch] > floor_lvl) ? lit[ch] - floor_lvl : 0;
                sums[ch]  = sums[ch] - history[ch][slot] + value[ch];
                history[ch][slot] = value[ch];
            end
            // averages compared as sums against level times window (twice that for the front pair)
            side_lim  = int'(regs[CFG_SIDE_WALL]) * WIN_LEN;
            front_lim = 2 * int'(regs[CFG_FRONT_WALL]) * WIN_LEN;
            r            = '0;
            r.fl_value   = ADC_W'(value[CH_FL]);
            r.fr_value   = ADC_W'(value[CH_FR]);
            r.dl_value   = ADC_W'(value[CH_DL]);
            r.dr_value   = ADC_W'(value[CH_DR]);
            r.left_wall  = sums[CH_DL] > side_lim;
            r.right_wall = sums[CH_DR] > side_lim;
            r.front_wall = (sums[CH_FL] + sums[CH_FR]) > front_lim;
            r.front_near = (value[CH_FL] > int'(regs[CFG_FRONT_NEAR])) ||
                           (value[CH_FR] > int'(regs[CFG_FRONT_NEAR]));
            r.left_near  = value[CH_DL] > int'(regs[CFG_SIDE_NEAR]);
            r.right_near = value[CH_DR] > int'(regs[CFG_SIDE_NEAR]);
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= RPT_MAX) begin
                $display("[%0t] MISMATCH %s", $time, msg);
            end
        endtask

        task check_field(string name, logic [ADC_W-1:0] got, logic [ADC_W-1:0] want);
            if (got !== want) begin
                report($sformatf("%s: got %0d, expected %0d", name, got, want));
            end
        endtask

        task check_result(logic [M_W-1:0] data);
            result_beat_t got;
            result_beat_t want;
            got = data;
            if (expected_q.size() == 0) begin
                report("result beat with no scan pending");
                return;
            end
            want = expected_q.pop_front();
            check_field("fl_value", got.fl_value, want.fl_value);
            check_field("fr_value", got.fr_value, want.fr_value);
            check_field("dl_value", got.dl_value, want.dl_value);
            check_field("dr_value", got.dr_value, want.dr_value);
            check_field("left_wall", ADC_W'(got.left_wall), ADC_W'(want.left_wall));
            check_field("right_wall", ADC_W'(got.right_wall), ADC_W'(want.right_wall));
            check_field("front_wall", ADC_W'(got.front_wall), ADC_W'(want.front_wall));
            check_field("front_near", ADC_W'(got.front_near), ADC_W'(want.front_near));
            check_field("left_near", ADC_W'(got.left_near), ADC_W'(want.left_near));
            check_field("right_near", ADC_W'(got.right_near), ADC_W'(want.right_near));
        endtask
    endclass

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic [S_W-1:0]       s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [M_W-1:0]       m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADC_W-1:0]     cfg_data  = '0;

    sensor_scoreboard board = new();

    // receiver pattern state
    rx_style_t rx_mode      = RX_OPEN;
    int        rx_left      = 0;
    int        hold_left    = 0;
    int        holds_asked  = 0;
    int        holds_served = 0;

    // sender pattern state
    int        burst_left   = 0;
    int        scene_left   = 0;
    int        scene_base [NUM_CH];

    ir_wall_sensor_conditioner #(
        .WINDOW_LEN (WIN_LEN),
        .ADC_BITS   (ADC_W)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Result side: check each beat, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_result(m_tdata);
        end
        if (holds_served < holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (rx_left == 0) begin
            rx_mode = rx_style_t'($urandom_range(0, 3));
            rx_left = $urandom_range(5, 80);
        end else begin
            rx_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ~m_tready;
            endcase
        end
    end

    // Watchdog: ends the run when no beat moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("** ir_wall_sensor_conditioner: FAILED **");
        $finish;
    end

    function automatic logic [ADC_W-1:0] pick_reading();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 1) ? ADC_W'(ADC_MAX) : '0;
        end
        return ADC_W'($urandom_range(0, ADC_MAX));
    endfunction

    // ambient/lit pair whose corrected value is v (or a target code) under the given offset
    function automatic void to_channel(int offset, int v, output logic [ADC_W-1:0] amb,
                                       output logic [ADC_W-1:0] lit);
        int top;
        if (v == V_RAW) begin
            amb = pick_reading();
            lit = pick_reading();
        end else if (v == V_BELOW) begin
            amb = ADC_W'($urandom_range(0, ADC_MAX));
            top = int'(amb) + offset;
            if (top > ADC_MAX) top = ADC_MAX;
            lit = ADC_W'($urandom_range(0, top));
        end else if (v + offset > ADC_MAX) begin
            // unreachable target, take the largest value there is
            amb = '0;
            lit = ADC_W'(ADC_MAX);
        end else begin
            amb = ADC_W'($urandom_range(0, ADC_MAX - offset - v));
            lit = ADC_W'(int'(amb) + offset + v);
        end
    endfunction

    function automatic scan_beat_t scan_for(int v [NUM_CH]);
        logic [ADC_W-1:0] amb [NUM_CH];
        logic [ADC_W-1:0] lit [NUM_CH];
        scan_beat_t       b;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            to_channel(int'(board.regs[int'(CFG_OFS_FL) + ch]), v[ch], amb[ch], lit[ch]);
        end
        b.fl_ambient = amb[CH_FL];
        b.fl_lit     = lit[CH_FL];
        b.fr_ambient = amb[CH_FR];
        b.fr_lit     = lit[CH_FR];
        b.dl_ambient = amb[CH_DL];
        b.dl_lit     = lit[CH_DL];
        b.dr_ambient = amb[CH_DR];
        b.dr_lit     = lit[CH_DR];
        return b;
    endfunction

    function automatic scan_beat_t flat_scan(logic [ADC_W-1:0] amb, logic [ADC_W-1:0] lit);
        return '{lit, amb, lit, amb, lit, amb, lit, amb};
    endfunction

    // Scenes hold each channel near a level for a while so the windowed
    // averages wander across the wall thresholds.
    function automatic scan_beat_t random_scan();
        int v [NUM_CH];
        int r;
        int wall_lvl;
        int near_lvl;
        bit is_front;
        if (scene_left == 0) begin
            scene_left = $urandom_range(20, 60);
            for (int ch = 0; ch < NUM_CH; ch++) begin
                is_front = (ch == CH_FL) || (ch == CH_FR);
                wall_lvl = is_front ? int'(board.regs[CFG_FRONT_WALL])
                                    : int'(board.regs[CFG_SIDE_WALL]);
                r = $urandom_range(0, 9);
                if (r < 6) scene_base[ch] = wall_lvl + $urandom_range(0, 120) - 60;
                else if (r < 8) scene_base[ch] = $urandom_range(0, ADC_MAX);
                else scene_base[ch] = 0;
            end
        end else begin
            scene_left--;
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            is_front = (ch == CH_FL) || (ch == CH_FR);
            near_lvl = is_front ? int'(board.regs[CFG_FRONT_NEAR])
                                : int'(board.regs[CFG_SIDE_NEAR]);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                v[ch] = scene_base[ch] + $urandom_range(0, 80) - 40;
                if (v[ch] < 0) v[ch] = 0;
            end else if (r < 72) begin
                v[ch] = near_lvl + $urandom_range(0, 6) - 3;
                if (v[ch] < 0) v[ch] = 0;
            end else if (r < 82) begin
                v[ch] = V_BELOW;
            end else begin
                v[ch] = V_RAW;
            end
        end
        return scan_for(v);
    endfunction

    task automatic push_scan(scan_beat_t b);
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_scan(b);
    endtask

    // bursts of random length, random gaps between them
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) begin
            push_scan(random_scan());
            pace();
        end
    endtask

    // stop offering, wait for every expected beat, then let the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // writes every register in index order, then some out-of-map indexes
    task automatic write_regs(int vals [NUM_REGS], int bad_writes);
        logic [CFG_IDX_W-1:0] idx;
        logic [ADC_W-1:0]     data;
        wait_drained();
        cfg_valid <= 1'b1;
        for (int k = 0; k < NUM_REGS + bad_writes; k++) begin
            if (k < NUM_REGS) begin
                idx  = CFG_IDX_W'(k);
                data = ADC_W'(vals[k]);
            end else begin
                idx  = CFG_IDX_W'((k == NUM_REGS) ? NUM_REGS :
                                  (k == NUM_REGS + 1) ? IDX_TOP :
                                  $urandom_range(NUM_REGS, IDX_TOP));
                data = ADC_W'($urandom_range(0, ADC_MAX));
            end
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            board.write_reg(idx, data);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int setting [NUM_REGS];
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, floor boundary, near levels, filling the windows
        push_scan(flat_scan('0, '0));
        push_scan(flat_scan(ADC_W'(ADC_MAX), ADC_W'(ADC_MAX)));
        push_scan(flat_scan('0, ADC_W'(ADC_MAX)));
        push_scan(flat_scan(ADC_W'(ADC_MAX), '0));
        push_scan(scan_for('{0, 0, 0, 0}));
        push_scan(scan_for('{1, 1, 1, 1}));
        push_scan(scan_for('{RST_FRONT_NEAR, RST_FRONT_NEAR + 1,
                             RST_SIDE_NEAR, RST_SIDE_NEAR + 1}));
        push_scan(scan_for('{RST_FRONT_NEAR + 1, RST_FRONT_NEAR,
                             RST_SIDE_NEAR + 1, RST_SIDE_NEAR}));
        push_scan(scan_for('{ADC_MAX, ADC_MAX, ADC_MAX, ADC_MAX}));
        push_scan(scan_for('{V_BELOW, V_BELOW, V_BELOW, V_BELOW}));
        repeat (12) push_scan(scan_for('{200, 200, 600, 400}));
        run_random(228);

        // everything at zero, plus dropped writes
        foreach (setting[k]) setting[k] = 0;
        write_regs(setting, 3);
        run_random(250);

        // everything at full scale
        foreach (setting[k]) setting[k] = ADC_MAX;
        write_regs(setting, 2);
        run_random(150);

        // small offsets, mid levels; receiver holds off while scans keep coming
        for (int k = int'(CFG_OFS_FL); k <= int'(CFG_OFS_DR); k++) begin
            setting[k] = $urandom_range(0, 200);
        end
        setting[CFG_SIDE_WALL]  = $urandom_range(100, 1500);
        setting[CFG_FRONT_WALL] = $urandom_range(50, 1000);
        setting[CFG_FRONT_NEAR] = $urandom_range(200, 3000);
        setting[CFG_SIDE_NEAR]  = $urandom_range(200, 3500);
        write_regs(setting, 0);
        run_random(100);
        holds_asked++;
        run_random(200);

        // fully random settings; the sender pauses until all results are in
        foreach (setting[k]) setting[k] = $urandom_range(0, ADC_MAX);
        write_regs(setting, 1);
        run_random(150);
        wait_drained();
        run_random(150);

        // back to the power-on values
        setting[CFG_OFS_FL]     = RST_OFS_FL;
        setting[CFG_OFS_FR]     = RST_OFS_FR;
        setting[CFG_OFS_DL]     = RST_OFS_DL;
        setting[CFG_OFS_DR]     = RST_OFS_DR;
        setting[CFG_SIDE_WALL]  = RST_SIDE_WALL;
        setting[CFG_FRONT_WALL] = RST_FRONT_WALL;
        setting[CFG_FRONT_NEAR] = RST_FRONT_NEAR;
        setting[CFG_SIDE_NEAR]  = RST_SIDE_NEAR;
        write_regs(setting, 0);
        run_random(400);

        wait_drained();
        repeat (10) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("** ir_wall_sensor_conditioner: PASSED **");
        end else begin
            $display("** ir_wall_sensor_conditioner: FAILED **");
        end
        $finish;
    end

endmodule
